// ===== design/arb_pkg.sv =====
`timescale 1ns / 1ps

package arb_pkg;

  localparam int DATA_W      = 32;
  localparam int ROW_LEN_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     row_end;
    logic                     matrix_end;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last;
    logic                     overflow;
  } out_t;

endpackage

// ===== design/arb_ram.sv =====
`timescale 1ns / 1ps

module arb_ram #(
  parameter int DEPTH = arb_pkg::ROW_LEN_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [arb_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [arb_pkg::DATA_W-1:0] rdata_o
);
  import arb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/arb_cmp.sv =====
`timescale 1ns / 1ps

module arb_cmp (
  input  logic [arb_pkg::DATA_W-1:0] prev_i,
  input  logic [arb_pkg::DATA_W-1:0] cand_i,
  input  logic                       desc_i,
  output logic                       move_o
);
  import arb_pkg::*;

  logic signed [DATA_W-1:0] prev_s;
  logic signed [DATA_W-1:0] cand_s;

  assign prev_s = $signed(prev_i);
  assign cand_s = $signed(cand_i);

  // shift the stored element up when it is out of order against the candidate
  assign move_o = desc_i ? (cand_s > prev_s) : (prev_s > cand_s);

endmodule

// ===== design/alternating_row_sorter.sv =====
`timescale 1ns / 1ps

// Row sorter with alternating direction.
// Input: one matrix element per transaction, taken at a clock edge with start
// high and busy low. row_end closes a row, matrix_end closes the matrix (and
// the row). Each element is insertion-sorted into a row buffer as it arrives:
// even rows ascending, odd rows descending; parity returns to even after
// matrix_end.
// An element that lands behind n buffered elements keeps busy high while it
// is placed, set by the single read port of the row buffer and one shared
// comparator (one read and one compare per buffered element passed, one
// final write). At row end the sorted row streams out one result per cycle
// from the registered read port of the row buffer. Each result shows for
// one cycle with result_valid_o; last marks the final element; overflow
// marks a row that had elements past ROW_LEN dropped. An element past
// ROW_LEN without row end leaves busy low. The receiver cannot stall the
// output. Reset clears fill count, parity and overflow flag; the buffer
// itself needs no clearing.
module alternating_row_sorter #(
  parameter int ROW_LEN = arb_pkg::ROW_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  arb_pkg::in_t  in_i,
  output logic          result_valid_o,
  output arb_pkg::out_t out_o
);
  import arb_pkg::*;

  localparam int AW = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
  localparam int CW = $clog2(ROW_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     j_q, j_d;
  logic [AW-1:0]     k_q, k_d;
  logic [DATA_W-1:0] v_q, v_d;
  logic              end_q, end_d;
  logic              mend_q, mend_d;
  logic              odd_q, odd_d;
  logic              ovf_q, ovf_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic              ovfo_q, ovfo_d;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic              move;
  logic              accept;
  logic              emit_last;

  arb_ram #(
    .DEPTH (ROW_LEN),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  arb_cmp u_cmp (
    .prev_i (rdata),
    .cand_i (v_q),
    .desc_i (odd_q),
    .move_o (move)
  );

  assign accept    = start && !busy;
  assign emit_last = ((CW'(k_q) + CW'(1)) == fill_q);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    j_d     = j_q;
    k_d     = k_q;
    v_d     = v_q;
    end_d   = end_q;
    mend_d  = mend_q;
    odd_d   = odd_q;
    ovf_d   = ovf_q;
    valid_d = 1'b0;
    last_d  = last_q;
    ovfo_d  = ovfo_q;
    we      = 1'b0;
    waddr   = j_q;
    wdata   = v_q;
    re      = 1'b0;
    raddr   = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          end_d  = in_i.row_end || in_i.matrix_end;
          mend_d = in_i.matrix_end;
          if (fill_q == CW'(ROW_LEN)) begin
            // drop the element, flag the row
            ovf_d = 1'b1;
            if (in_i.row_end || in_i.matrix_end) begin
              k_d     = '0;
              state_d = S_EMIT;
            end
          end else begin
            v_d     = in_i.value;
            j_d     = fill_q[AW-1:0];
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (j_q == '0) begin
          we     = 1'b1;
          waddr  = '0;
          wdata  = v_q;
          fill_d = fill_q + CW'(1);
          k_d    = '0;
          state_d = end_q ? S_EMIT : S_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = j_q - AW'(1);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = j_q;
        if (move) begin
          wdata   = rdata;
          j_d     = j_q - AW'(1);
          state_d = S_READ;
        end else begin
          wdata   = v_q;
          fill_d  = fill_q + CW'(1);
          k_d     = '0;
          state_d = end_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        re      = 1'b1;
        raddr   = k_q;
        valid_d = 1'b1;
        last_d  = emit_last;
        ovfo_d  = ovf_q;
        if (emit_last) begin
          fill_d  = '0;
          ovf_d   = 1'b0;
          odd_d   = mend_q ? 1'b0 : !odd_q;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      odd_q   <= 1'b0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      odd_q   <= odd_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    k_q    <= k_d;
    v_q    <= v_d;
    end_q  <= end_d;
    mend_q <= mend_d;
    last_q <= last_d;
    ovfo_q <= ovfo_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

  always_comb begin
    out_o.sorted_value = $signed(rdata);
    out_o.last         = last_q;
    out_o.overflow     = ovfo_q;
  end

  a_valid_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_EMIT))
    else $error("result strobe without a preceding emit cycle");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ROW_LEN))
    else $error("fill count beyond row buffer");

  a_gap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_o.last) |=> !result_valid_o)
    else $error("result strobe right after the last element of a row");

endmodule
